@@ rtl/cpd_pkg.sv @@
package cpd_pkg;

    localparam int unsigned DEF_MAX_ROWS = 1024;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STEP_W   = 31;
    localparam int unsigned NROWS_W  = 11;
    localparam int unsigned ROW_W    = 10;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [ACTION_W-1:0] ACT_POINT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FLUSH   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

    localparam logic [KIND_W-1:0] KIND_KEEP   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REFUSE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

endpackage

@@ rtl/cpd_row_div.sv @@
module cpd_row_div
    import cpd_pkg::*;
#(
    parameter int unsigned QW = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [32:0]       i_span,
    input  logic [STEP_W-1:0] i_step,
    output logic              o_done,
    output logic              o_ovf,
    output logic [QW-1:0]     o_quot
);

    localparam int unsigned W  = 33 + QW;
    localparam int unsigned CW = $clog2(QW) + 1;

    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_div;
    logic [QW-1:0] r_q;
    logic          r_ovf;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          w_ge;

    assign w_ge = (r_rem >= r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // one quotient bit a cycle, most significant first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= W'(i_span);
            r_div <= W'(i_step) << (QW - 1);
            r_q   <= '0;
            r_ovf <= (W'(i_span) >= (W'(i_step) << QW));
            r_cnt <= CW'(QW - 1);
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_div;
            end
            r_q   <= (r_q << 1) | QW'(w_ge);
            r_div <= r_div >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_quot = r_q;

endmodule

@@ rtl/cpd_stamp_ram.sv @@
module cpd_stamp_ram
    import cpd_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_MAX_ROWS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pixel_column_point_decimator.sv @@
// Flow: a flush or restart goes from the request straight to the emit state and
// the output register; a point passes the row divider (one quotient bit per
// cycle), then a stamp memory read and write-back; a clamped y skips the divider.
// Requests: one at a time; the next is taken once the last one's results have
// left the emit state, so a second result or an output stall delays it.
// Reset: synchronous, active low; afterwards the stamp memory is cleared in a
// pass over all MAX_ROWS rows during which input stays stalled.
module pixel_column_point_decimator
    import cpd_pkg::*;
#(
    parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [DATA_W-1:0]          i_cfg_data,
    // requests
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [ACTION_W-1:0]        i_action,
    input  logic signed [DATA_W-1:0]   i_x_time,
    input  logic signed [DATA_W-1:0]   i_y_value,
    input  logic [DATA_W-1:0]          i_record_id,
    // results
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [KIND_W-1:0]          o_kind,
    output logic [DATA_W-1:0]          o_out_record,
    output logic signed [DATA_W-1:0]   o_out_x,
    output logic signed [DATA_W-1:0]   o_out_y,
    output logic [ROW_W-1:0]           o_row,
    output logic [COUNT_W-1:0]         o_column_count
);

    localparam int unsigned RW = $clog2(MAX_ROWS);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DIV, S_READ, S_CHECK, S_EMIT
    } t_state;

    t_state r_state;

    // configuration registers
    logic signed [DATA_W-1:0] r_y_low, r_y_high;
    logic [STEP_W-1:0]        r_y_step, r_x_step;
    logic [NROWS_W-1:0]       r_num_rows;

    // column state
    logic [DATA_W-1:0]        r_stamp;
    logic signed [DATA_W-1:0] r_column_x;
    logic                     r_need_first;
    logic [COUNT_W-1:0]       r_kept;

    // request being worked on
    logic signed [DATA_W-1:0] r_x, r_y;
    logic [DATA_W-1:0]        r_rec;
    logic [RW-1:0]            r_row;
    logic [RW-1:0]            r_clr_addr;

    // pending results: slot A is close/refuse, slot B is the kept point
    logic                     r_pa_valid;
    logic [KIND_W-1:0]        r_pa_kind;
    logic [COUNT_W-1:0]       r_pa_count;
    logic                     r_pb_valid;
    logic [COUNT_W-1:0]       r_pb_count;

    // output register
    logic                     r_out_valid;
    logic [KIND_W-1:0]        r_o_kind;
    logic [DATA_W-1:0]        r_o_rec;
    logic [DATA_W-1:0]        r_o_x, r_o_y;
    logic [ROW_W-1:0]         r_o_row;
    logic [COUNT_W-1:0]       r_o_count;

    logic                     w_accept, w_out_free;
    logic [RW-1:0]            w_last;
    logic [31:0]              w_rows;
    logic signed [32:0]       w_dx;
    logic [32:0]              w_adx;
    logic                     w_leave;
    logic [32:0]              w_span;
    logic [STEP_W-1:0]        w_step;
    logic                     w_div_start, w_div_done, w_div_ovf;
    logic [RW-1:0]            w_quot;
    logic                     w_we;
    logic [RW-1:0]            w_waddr;
    logic [DATA_W-1:0]        w_wdata, w_rdata;
    logic                     w_new_row;
    logic [COUNT_W-1:0]       w_kept_inc;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // rows in use, clamped to [1, MAX_ROWS]
    always_comb begin
        w_rows = 32'(r_num_rows);
        if (w_rows == 32'd0) begin
            w_rows = 32'd1;
        end else if (w_rows > 32'(MAX_ROWS)) begin
            w_rows = 32'(MAX_ROWS);
        end
    end
    assign w_last = RW'(w_rows - 32'd1);

    // column membership: |x - column_x| > x_step leaves the column
    assign w_dx    = 33'(i_x_time) - 33'(r_column_x);
    assign w_adx   = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
    assign w_leave = !r_need_first && (w_adx > 33'(r_x_step));

    assign w_span = 33'(33'(i_y_value) - 33'(r_y_low));
    assign w_step = (r_y_step == '0) ? STEP_W'(1) : r_y_step;

    assign w_div_start = w_accept && (i_action == ACT_POINT)
                      && !(i_y_value < r_y_low) && !(i_y_value >= r_y_high);

    cpd_row_div #(.QW(RW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_span  (w_span),
        .i_step  (w_step),
        .o_done  (w_div_done),
        .o_ovf   (w_div_ovf),
        .o_quot  (w_quot)
    );

    // stamp memory: clear pass writes zero, otherwise stamp the point's row
    assign w_new_row  = (r_state == S_CHECK) && (w_rdata != r_stamp);
    assign w_we       = (r_state == S_CLEAR) || w_new_row;
    assign w_waddr    = (r_state == S_CLEAR) ? r_clr_addr : r_row;
    assign w_wdata    = (r_state == S_CLEAR) ? '0 : r_stamp;
    assign w_kept_inc = (r_kept == COUNT_MAX) ? r_kept : r_kept + 1'b1;

    cpd_stamp_ram #(.DEPTH(MAX_ROWS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_row),
        .o_rdata (w_rdata)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_low    <= '0;
            r_y_high   <= 32'sd65536;
            r_y_step   <= STEP_W'(65536);
            r_x_step   <= '0;
            r_num_rows <= NROWS_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_Y_LOW:    r_y_low    <= i_cfg_data;
                REG_Y_HIGH:   r_y_high   <= i_cfg_data;
                REG_Y_STEP:   r_y_step   <= i_cfg_data[STEP_W-1:0];
                REG_X_STEP:   r_x_step   <= i_cfg_data[STEP_W-1:0];
                REG_NUM_ROWS: r_num_rows <= i_cfg_data[NROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // request sequencer with column state and result staging
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_stamp      <= 32'd1;
            r_column_x   <= '0;
            r_need_first <= 1'b1;
            r_kept       <= '0;
            r_pa_valid   <= 1'b0;
            r_pb_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // drop the accepted result unless a pending one replaces it
            if (!i_out_stall && !(r_state == S_EMIT && (r_pa_valid || r_pb_valid))) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == RW'(MAX_ROWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_x   <= i_x_time;
                        r_y   <= i_y_value;
                        r_rec <= i_record_id;
                        case (i_action)
                            ACT_FLUSH: begin
                                // close a non-empty column, keep column_x
                                r_state <= S_EMIT;
                                if (r_kept != '0) begin
                                    r_pa_valid <= 1'b1;
                                    r_pa_kind  <= KIND_CLOSE;
                                    r_pa_count <= r_kept;
                                    r_kept     <= '0;
                                    r_stamp    <= r_stamp + 1'b1;
                                end
                            end
                            ACT_RESTART: begin
                                // refuse while the column holds points
                                r_state <= S_EMIT;
                                if (r_kept != '0) begin
                                    r_pa_valid <= 1'b1;
                                    r_pa_kind  <= KIND_REFUSE;
                                    r_pa_count <= r_kept;
                                end else begin
                                    r_need_first <= 1'b1;
                                end
                            end
                            ACT_POINT: begin
                                if (r_need_first) begin
                                    r_column_x   <= i_x_time;
                                    r_need_first <= 1'b0;
                                end else if (w_leave) begin
                                    r_column_x <= i_x_time;
                                    if (r_kept != '0) begin
                                        r_pa_valid <= 1'b1;
                                        r_pa_kind  <= KIND_CLOSE;
                                        r_pa_count <= r_kept;
                                        r_kept     <= '0;
                                        r_stamp    <= r_stamp + 1'b1;
                                    end
                                end
                                // clamped rows skip the divider
                                if (i_y_value < r_y_low) begin
                                    r_row   <= '0;
                                    r_state <= S_READ;
                                end else if (i_y_value >= r_y_high) begin
                                    r_row   <= w_last;
                                    r_state <= S_READ;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            default: r_state <= S_EMIT;
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_row   <= (w_div_ovf || w_quot > w_last) ? w_last : w_quot;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    // stamp the row and count the point when it is new here
                    if (w_new_row) begin
                        r_kept     <= w_kept_inc;
                        r_pb_valid <= 1'b1;
                        r_pb_count <= w_kept_inc;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // drain slot A before slot B to keep result order
                    if (w_out_free) begin
                        if (r_pa_valid) begin
                            r_pa_valid  <= 1'b0;
                            r_out_valid <= 1'b1;
                            r_o_kind    <= r_pa_kind;
                            r_o_rec     <= '0;
                            r_o_x       <= '0;
                            r_o_y       <= '0;
                            r_o_row     <= '0;
                            r_o_count   <= r_pa_count;
                            if (!r_pb_valid) begin
                                r_state <= S_IDLE;
                            end
                        end else if (r_pb_valid) begin
                            r_pb_valid  <= 1'b0;
                            r_out_valid <= 1'b1;
                            r_o_kind    <= KIND_KEEP;
                            r_o_rec     <= r_rec;
                            r_o_x       <= r_x;
                            r_o_y       <= r_y;
                            r_o_row     <= ROW_W'(r_row);
                            r_o_count   <= r_pb_count;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_o_kind;
    assign o_out_record   = r_o_rec;
    assign o_out_x        = r_o_x;
    assign o_out_y        = r_o_y;
    assign o_row          = r_o_row;
    assign o_column_count = r_o_count;

    // divider finishes only while a point waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("row divider finished outside divide state");

    // closed or refused columns always report a nonzero count
    a_close_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_CLOSE || o_kind == KIND_REFUSE))
            |-> o_column_count != '0)
        else $error("column result with zero count");

    // a kept point follows a stamp write in the previous check cycle
    a_keep_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && w_new_row) |=> r_pb_valid && r_kept != '0)
        else $error("new row not staged as kept point");

endmodule
